/* rtl/core/b64enc_pkg.sv */
// Shared types, constants and the character lookup for the base64 stream encoder.
// Depends on nothing; every other file of the encoder refers to it by scoped names.
package b64enc_pkg;

    // Group queue depth and pointer width
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Character codes
    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_UPPER = 8'h41;
    localparam logic [7:0] CHAR_LOWER = 8'h61;
    localparam logic [7:0] CHAR_DIGIT = 8'h30;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    // Character counts per group
    localparam logic [2:0] NCHARS_TWO   = 3'd2;
    localparam logic [2:0] NCHARS_THREE = 3'd3;
    localparam logic [2:0] NCHARS_FOUR  = 3'd4;

    // Pending byte counts
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    // One group handed from front to back
    typedef struct packed {
        logic [23:0] bits;
        logic [2:0]  nchars;
    } grp_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

    // Map a sextet to its alphabet character
    function automatic logic [7:0] sextet_char(input logic [5:0] s);
        logic [7:0] c;
        c = {2'b00, s};
        if (s < 6'd26) begin
            sextet_char = CHAR_UPPER + c;
        end else if (s < 6'd52) begin
            sextet_char = CHAR_LOWER + c - 8'd26;
        end else if (s < 6'd62) begin
            sextet_char = CHAR_DIGIT + c - 8'd52;
        end else if (s == 6'd62) begin
            sextet_char = CHAR_PLUS;
        end else begin
            sextet_char = CHAR_SLASH;
        end
    endfunction

endpackage

/* rtl/core/base64_stream_encoder_top.sv */
// Top level of the base64 stream encoder (standard alphabet, '=' padding).
// Depends on b64enc_pkg, b64enc_front, b64enc_gqueue and b64enc_back.
//
// Usage:
//   Input queue side: drive data_byte and end_of_data with push; a byte is
//   taken at a clock edge where push is high and full is low. Set end_of_data
//   on the final byte of a stream; the next byte starts a new stream.
//   Result queue side: while empty is low, out_char holds the oldest
//   character; pop at an edge with empty low takes it. run_last marks the
//   fourth character of each group.
//   A byte that completes a group (third byte or final byte) passes through
//   the group queue and the back end's group register to the output register.
//   Throughput: while pop keeps draining, the back end emits one character
//   per cycle, four for each group of three bytes. Bytes are taken one per cycle
//   until the two-entry group queue fills; full follows queue occupancy.
//   When pop stays low, the output register holds, the back end stops, the
//   group queue fills and full rises; nothing is dropped.
//   Reset clears pending bytes, the group queue and the output register.
module base64_stream_encoder_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       end_of_data,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_char,
    output logic       run_last
);

    logic                in_accept;
    logic                grp_wr;
    b64enc_pkg::grp_t    grp_wr_data;
    b64enc_pkg::grp_t    grp_rd_data;
    logic                grp_rd;
    b64enc_pkg::qstat_t  q_stat;

    assign full      = q_stat.full;
    assign in_accept = push && !q_stat.full;

    b64enc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .data_byte   (data_byte),
        .end_of_data (end_of_data),
        .grp_wr      (grp_wr),
        .grp_data    (grp_wr_data)
    );

    b64enc_gqueue u_gqueue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (grp_wr),
        .wr_data (grp_wr_data),
        .rd      (grp_rd),
        .rd_data (grp_rd_data),
        .stat    (q_stat)
    );

    b64enc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_data  (grp_rd_data),
        .grp_avail (!q_stat.empty),
        .grp_rd    (grp_rd),
        .pop       (pop),
        .empty     (empty),
        .out_char  (out_char),
        .run_last  (run_last)
    );

    // A final byte always produces a group
    a_final_writes: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && end_of_data |-> grp_wr)
        else $error("final byte did not produce a group");

    // Group writes only happen on an input transaction
    a_wr_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        grp_wr |-> in_accept)
        else $error("group written without an input transaction");

    // Queue status is consistent
    a_qstat: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.empty && q_stat.full))
        else $error("group queue both empty and full");

    // A group write into an empty queue while the output is empty must yield a character
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        grp_wr && q_stat.empty && empty |-> ##[1:3] !empty)
        else $error("group did not reach the output in time");

endmodule

/* rtl/core/b64enc_front.sv */
// Front of the base64 encoder: collects bytes into 24-bit groups and classifies them.
// Depends on b64enc_pkg; writes finished groups into b64enc_gqueue.
module b64enc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                end_of_data,
    output logic                grp_wr,
    output b64enc_pkg::grp_t    grp_data
);

    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic [15:0] bytes_reg;
    logic [15:0] bytes_next;
    logic [1:0]  cnt_eff;

    // Classify the accepted byte against the pending bytes
    always_comb
    begin
        cnt_eff       = (cnt_reg == 2'd3) ? b64enc_pkg::CNT_NONE : cnt_reg;
        cnt_next      = cnt_reg;
        bytes_next    = bytes_reg;
        grp_wr        = 1'b0;
        grp_data      = '0;
        if (accept)
        begin
            if (cnt_eff == b64enc_pkg::CNT_TWO)
            begin
                grp_wr          = 1'b1;
                grp_data.bits   = {bytes_reg, data_byte};
                grp_data.nchars = b64enc_pkg::NCHARS_FOUR;
                cnt_next        = b64enc_pkg::CNT_NONE;
                bytes_next      = '0;
            end
            else if (!end_of_data)
            begin
                if (cnt_eff == b64enc_pkg::CNT_NONE)
                    bytes_next = {data_byte, 8'h00};
                else
                    bytes_next = {bytes_reg[15:8], data_byte};
                cnt_next = cnt_eff + 2'd1;
            end
            else
            begin
                grp_wr = 1'b1;
                if (cnt_eff == b64enc_pkg::CNT_NONE)
                begin
                    grp_data.bits   = {data_byte, 16'h0000};
                    grp_data.nchars = b64enc_pkg::NCHARS_TWO;
                end
                else
                begin
                    grp_data.bits   = {bytes_reg[15:8], data_byte, 8'h00};
                    grp_data.nchars = b64enc_pkg::NCHARS_THREE;
                end
                cnt_next   = b64enc_pkg::CNT_NONE;
                bytes_next = '0;
            end
        end
    end

    // Hold pending bytes and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= b64enc_pkg::CNT_NONE;
            bytes_reg <= '0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            bytes_reg <= bytes_next;
        end
    end

endmodule

/* rtl/core/b64enc_gqueue.sv */
// Short group queue between the front and back of the base64 encoder.
// Depends on b64enc_pkg for the group type, depth and status struct.
module b64enc_gqueue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  b64enc_pkg::grp_t    wr_data,
    input  logic                rd,
    output b64enc_pkg::grp_t    rd_data,
    output b64enc_pkg::qstat_t  stat
);

    b64enc_pkg::grp_t                      slots_reg [b64enc_pkg::QDEPTH];
    logic [b64enc_pkg::QPTR_W-1:0]         wptr_reg;
    logic [b64enc_pkg::QPTR_W-1:0]         wptr_next;
    logic [b64enc_pkg::QPTR_W-1:0]         rptr_reg;
    logic [b64enc_pkg::QPTR_W-1:0]         rptr_next;
    logic [b64enc_pkg::QCNT_W-1:0]         cnt_reg;
    logic [b64enc_pkg::QCNT_W-1:0]         cnt_next;
    logic                                  do_wr;
    logic                                  do_rd;

    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == b64enc_pkg::QCNT_W'(b64enc_pkg::QDEPTH));
    assign do_wr      = wr && !stat.full;
    assign do_rd      = rd && !stat.empty;
    assign rd_data    = slots_reg[rptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr)
            wptr_next = (wptr_reg == b64enc_pkg::QPTR_W'(b64enc_pkg::QDEPTH - 1))
                        ? '0 : wptr_reg + 1'b1;
        if (do_rd)
            rptr_next = (rptr_reg == b64enc_pkg::QPTR_W'(b64enc_pkg::QDEPTH - 1))
                        ? '0 : rptr_reg + 1'b1;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Store the written group
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slots_reg[wptr_reg] <= wr_data;
    end

endmodule

/* rtl/core/b64enc_back.sv */
// Back of the base64 encoder: expands a group into four characters, one per cycle unless stalled.
// Depends on b64enc_pkg for the group type and the alphabet lookup.
module b64enc_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  b64enc_pkg::grp_t    grp_data,
    input  logic                grp_avail,
    output logic                grp_rd,
    input  logic                pop,
    output logic                empty,
    output logic [7:0]          out_char,
    output logic                run_last
);

    logic        busy_reg;
    logic        busy_next;
    logic [23:0] bits_reg;
    logic [2:0]  nchars_reg;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic        oval_reg;
    logic        oval_next;
    logic [7:0]  char_reg;
    logic        last_reg;
    logic        advance;
    logic        load;
    logic [5:0]  sextet;
    logic [7:0]  char_now;

    // Move a character into the output register when it is free or being drained
    assign advance = busy_reg && (!oval_reg || pop);
    assign grp_rd  = !busy_reg || (advance && idx_reg == 2'd3);
    assign load    = grp_rd && grp_avail;

    // Select the sextet for the current character, most significant first
    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = bits_reg[23:18];
            2'd1:    sextet = bits_reg[17:12];
            2'd2:    sextet = bits_reg[11:6];
            default: sextet = bits_reg[5:0];
        endcase
        char_now = ({1'b0, idx_reg} < nchars_reg) ? b64enc_pkg::sextet_char(sextet)
                                                  : b64enc_pkg::CHAR_PAD;
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        oval_next = oval_reg;
        if (oval_reg && pop)
            oval_next = 1'b0;
        if (advance)
        begin
            oval_next = 1'b1;
            idx_next  = idx_reg + 2'd1;
            if (idx_reg == 2'd3)
                busy_next = 1'b0;
        end
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
            oval_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            oval_reg <= oval_next;
        end
    end

    // Latch the group and the output character
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bits_reg   <= grp_data.bits;
            nchars_reg <= grp_data.nchars;
        end
        if (advance)
        begin
            char_reg <= char_now;
            last_reg <= (idx_reg == 2'd3);
        end
    end

    assign empty    = !oval_reg;
    assign out_char = char_reg;
    assign run_last = last_reg;

endmodule

/* verif/b64enc_scoreboard_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard for the base64 stream encoder: predicts characters from accepted bytes.
// Depends on b64enc_pkg for the pad character, group sizes and pending-count codes.
package b64enc_scoreboard_pkg;

    // One expected output character
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } char_entry_t;

    class b64_char_board;

        char_entry_t expected_chars[$];
        logic [15:0] held_bytes;
        logic [1:0]  held_count;
        string       alphabet;
        int          mismatches;

        function new();
            alphabet   = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            held_bytes = 16'h0000;
            held_count = b64enc_pkg::CNT_NONE;
            mismatches = 0;
        endfunction

        function int waiting();
            return expected_chars.size();
        endfunction

        // Queue four characters: nchars from the group, '=' for the rest
        function void queue_group(logic [23:0] grp, logic [2:0] nchars);
            char_entry_t entry;
            logic [5:0]  sextet;
            for (int k = 0; k < 4; k++)
            begin
                sextet = grp[23 - 6 * k -: 6];
                entry.code = (k < nchars) ? alphabet[int'(sextet)] : b64enc_pkg::CHAR_PAD;
                entry.last = (k == 3);
                expected_chars = {expected_chars, entry};
            end
        endfunction

        // Advance the pending-byte state for one accepted input transaction
        function void note_byte(logic [7:0] data, logic final_byte);
            case (held_count)
                b64enc_pkg::CNT_TWO:
                begin
                    queue_group({held_bytes, data}, b64enc_pkg::NCHARS_FOUR);
                    held_bytes = 16'h0000;
                    held_count = b64enc_pkg::CNT_NONE;
                end
                b64enc_pkg::CNT_ONE:
                begin
                    if (final_byte)
                    begin
                        queue_group({held_bytes[15:8], data, 8'h00},
                                    b64enc_pkg::NCHARS_THREE);
                        held_bytes = 16'h0000;
                        held_count = b64enc_pkg::CNT_NONE;
                    end
                    else
                    begin
                        held_bytes[7:0] = data;
                        held_count      = b64enc_pkg::CNT_TWO;
                    end
                end
                // A count of three never occurs; treat it as nothing pending
                default:
                begin
                    if (final_byte)
                    begin
                        queue_group({data, 16'h0000}, b64enc_pkg::NCHARS_TWO);
                        held_bytes = 16'h0000;
                        held_count = b64enc_pkg::CNT_NONE;
                    end
                    else
                    begin
                        held_bytes = {data, 8'h00};
                        held_count = b64enc_pkg::CNT_ONE;
                    end
                end
            endcase
        endfunction

        // Compare one accepted output transaction with the oldest expectation
        function void check_char(logic [7:0] got_code, logic got_last);
            char_entry_t want;
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected character: expected none, actual %h (last %b)",
                         $time, got_code, got_last);
                mismatches++;
                return;
            end
            want = expected_chars.pop_front();
            if (got_code !== want.code)
            begin
                $display("%0t: out_char mismatch: expected %h, actual %h",
                         $time, want.code, got_code);
                mismatches++;
            end
            if (got_last !== want.last)
            begin
                $display("%0t: run_last mismatch: expected %b, actual %b",
                         $time, want.last, got_last);
                mismatches++;
            end
        endfunction

    endclass

endpackage

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for base64_stream_encoder_top: drives byte streams, pops characters.
// Depends on b64enc_pkg, b64enc_scoreboard_pkg and the encoder RTL.
module tb_top;

    localparam int RANDOM_ITEMS  = 230;
    localparam int LONG_HOLD     = 200;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 20;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       push        = 1'b0;
    logic       full;
    logic [7:0] data_byte   = 8'h00;
    logic       end_of_data = 1'b0;
    logic       empty;
    logic       pop         = 1'b0;
    logic [7:0] out_char;
    logic       run_last;

    bit quiet_mode    = 1'b0;
    bit long_hold_req = 1'b0;
    int items_sent    = 0;

    b64enc_scoreboard_pkg::b64_char_board char_board = new();

    always #5 clk = ~clk;

    base64_stream_encoder_top i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .end_of_data (end_of_data),
        .empty       (empty),
        .pop         (pop),
        .out_char    (out_char),
        .run_last    (run_last)
    );

    // Sender gap: mostly none, some short, a few long
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    // Offer one byte and hold it until the transaction completes
    task automatic send_byte(input logic [7:0] data, input logic final_byte, input int gap);
        push        <= 1'b1;
        data_byte   <= data;
        end_of_data <= final_byte;
        do
            @(posedge clk);
        while (full);
        char_board.note_byte(data, final_byte);
        items_sent++;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Send one stream of len bytes, final flag on the last one
    task automatic send_stream(input int len, input bit extremes);
        logic [7:0] data;
        for (int i = 0; i < len; i++)
        begin
            if (extremes)
                data = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                data = 8'($urandom_range(0, 255));
            send_byte(data, i == len - 1, sender_gap());
        end
    endtask

    // Drop push and wait until every expected character has been popped
    task automatic drain_results();
        push <= 1'b0;
        while (char_board.waiting() != 0)
            @(posedge clk);
    endtask

    // Receiver: check each popped character, stall at random
    initial
    begin
        int stall_left;
        int r;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                char_board.check_char(out_char, run_last);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else if (quiet_mode)
                pop <= 1'b1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    pop <= 1'b1;
                else
                begin
                    pop <= 1'b0;
                    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Main sequence
    initial
    begin
        int random_start;
        int r;
        int len;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One-byte streams: two characters and double padding
        send_byte(8'h00, 1'b1, 0);
        send_byte(8'hFF, 1'b1, 1);
        // Two-byte stream: three characters and single padding
        send_byte(8'hFF, 1'b0, 0);
        send_byte(8'hFF, 1'b1, 0);
        // Final byte completes a group: no padding
        send_byte(8'hFF, 1'b0, 0);
        send_byte(8'hFF, 1'b0, 2);
        send_byte(8'hFF, 1'b1, 0);
        // All '+' sextets
        send_byte(8'hFB, 1'b0, 0);
        send_byte(8'hEF, 1'b0, 0);
        send_byte(8'hBE, 1'b1, 0);
        // Two full groups in one stream
        send_byte(8'h00, 1'b0, 0);
        send_byte(8'h10, 1'b0, 0);
        send_byte(8'h83, 1'b0, 0);
        send_byte(8'h10, 1'b0, 3);
        send_byte(8'h51, 1'b0, 0);
        send_byte(8'h87, 1'b1, 0);
        // Full group then a lone final byte
        send_byte(8'h4D, 1'b0, 0);
        send_byte(8'h61, 1'b0, 0);
        send_byte(8'h6E, 1'b0, 0);
        send_byte(8'h4D, 1'b1, 0);
        // Two zero bytes
        send_byte(8'h00, 1'b0, 0);
        send_byte(8'h00, 1'b1, 0);
        drain_results();

        // Hold the receiver off while the sender keeps pushing, so full rises
        quiet_mode    = 1'b1;
        long_hold_req = 1'b1;
        send_stream(24, 1'b0);
        quiet_mode = 1'b0;
        drain_results();

        // Random streams, mostly short, some long, occasionally drained
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            quiet_mode = ($urandom_range(0, 9) == 0);
            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(1, 6);
            else if (r < 95)
                len = $urandom_range(7, 15);
            else
                len = $urandom_range(16, 40);
            send_stream(len, $urandom_range(0, 9) == 0);
            if ($urandom_range(0, 9) == 0)
                drain_results();
        end
        quiet_mode = 1'b0;

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (char_board.mismatches == 0 && char_board.waiting() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
